@@ sv/assert_macros.svh @@
// Assertion macros used by the checker of the blink counter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted (active low reset).
`define EBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define EBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ebc_pkg.sv @@
// Shared types and constants of the eye blink counter.
// No dependencies; imported by ebc_dist_lane and eye_blink_counter_core.
package ebc_pkg;

  // Field widths
  localparam int COORD_W = 13;
  localparam int ABS_W   = 13;   // |difference| of two coordinates
  localparam int SQ_W    = 27;   // dx*dx + dy*dy
  localparam int RAD_W   = 44;   // radicand (sq << 16), padded to an even width
  localparam int DIST_W  = 22;   // distance in Q.8
  localparam int RATIO_W = 18;   // aspect ratio in Q2.16
  localparam int THR_W   = 16;
  localparam int RUN_W   = 8;
  localparam int CNT_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CLOSED      = 2'd1;

  // Register reset values
  localparam logic [THR_W-1:0] THR_RESET = 16'd13107;  // 0.2 in Q0.16
  localparam logic [RUN_W-1:0] MIN_RESET = 8'd4;

  // Step counts of the serial phases, stored as last index
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] MUL_LAST  = 5'd12;  // 13 multiplier bits
  localparam logic [STEP_W-1:0] SQRT_LAST = 5'd21;  // 22 root bits
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd17;  // 18 quotient bits

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQL,
    ST_SQRT,
    ST_DIVL,
    ST_DIV,
    ST_FIN
  } state_t;

  // Controls from the sequencer to each distance lane
  typedef struct packed {
    logic load;       // capture landmark pair
    logic mul_step;   // one bit of both squarings
    logic sqrt_load;  // sum squares, start the root
    logic sqrt_step;  // one bit of the root
  } lane_ctl_t;

endpackage

@@ sv/ebc_dist_lane.sv @@
// One distance lane: |p - q| squared bit-serially, then a bit-serial square root.
// Depends on ebc_pkg; driven by the sequencer in eye_blink_counter_core.
module ebc_dist_lane (
  input  logic                                clk,
  input  ebc_pkg::lane_ctl_t                  ctl,
  input  logic signed [ebc_pkg::COORD_W-1:0]  p_x,
  input  logic signed [ebc_pkg::COORD_W-1:0]  p_y,
  input  logic signed [ebc_pkg::COORD_W-1:0]  q_x,
  input  logic signed [ebc_pkg::COORD_W-1:0]  q_y,
  output logic        [ebc_pkg::DIST_W-1:0]   dist_q8
);
  import ebc_pkg::*;

  localparam int PROD_W = 2 * ABS_W + 1;   // {accumulator, multiplier}
  localparam int REM_W  = DIST_W + 1;

  logic signed [COORD_W:0] dx, dy;
  logic [ABS_W-1:0]        ax, ay;

  logic [ABS_W-1:0]  mcx_r, mcy_r;
  logic [PROD_W-1:0] px_r, py_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIST_W-1:0] root_r;

  logic [ABS_W+1:0]  sumx, sumy;
  logic [SQ_W-1:0]   sq;
  logic [REM_W+1:0]  rem_sh, trial, rem_sub;
  logic              ge;

  // Absolute differences, taken at the input transfer
  assign dx = {p_x[COORD_W-1], p_x} - {q_x[COORD_W-1], q_x};
  assign dy = {p_y[COORD_W-1], p_y} - {q_y[COORD_W-1], q_y};
  assign ax = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
  assign ay = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);

  // Shift-add squaring: add the multiplicand on a set low bit, shift right
  assign sumx = {1'b0, px_r[PROD_W-1:ABS_W]} + {2'b00, (px_r[0] ? mcx_r : '0)};
  assign sumy = {1'b0, py_r[PROD_W-1:ABS_W]} + {2'b00, (py_r[0] ? mcy_r : '0)};
  assign sq   = SQ_W'({1'b0, px_r[2*ABS_W-1:0]}) + SQ_W'({1'b0, py_r[2*ABS_W-1:0]});

  // Restoring square root, two radicand bits per step
  assign rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcx_r <= ax;
      mcy_r <= ay;
      px_r  <= {(PROD_W-ABS_W)'(0), ax};
      py_r  <= {(PROD_W-ABS_W)'(0), ay};
    end else if (ctl.mul_step) begin
      px_r <= {sumx, px_r[ABS_W-1:1]};
      py_r <= {sumy, py_r[ABS_W-1:1]};
    end

    if (ctl.sqrt_load) begin
      rad_r  <= {1'b0, sq, 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctl.sqrt_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[DIST_W-2:0], ge};
    end
  end

  assign dist_q8 = root_r;

endmodule

@@ sv/eye_blink_counter_core.sv @@
// Eye blink counter top level: input capture, sequencer, divider and blink state.
// Depends on ebc_pkg and ebc_dist_lane.
//
// Usage:
//   in_*  : one transfer carries the six landmarks of one eye for one frame.
//   out_* : one transfer per input carries the aspect ratio, the closed flag,
//           the blink flag and count, the closed run and the zero width flag.
//   cfg_* : register writes (threshold, minimum closed frames), taken any
//           cycle that cfg_we is high; write them only while the block is idle.
// Sequence:
//   Three distance lanes square bit-serially, then load the radicand and take
//   the root one bit per cycle; one shared restoring divider loads, then forms
//   18 quotient bits. The result register loads as the sequencer leaves
//   ST_FIN for ST_IDLE, which raises in_tready again, so a new item is taken
//   only after the sequencer is done with the last one.
//   in_tready is high only while no item is in the lanes.
// Reset (rst_n low, synchronous): registers go to their reset values, the
//   closed run and blink count clear and out_tvalid drops.
// Stall: a held result stays in the output register; the next item is still
//   accepted and computed, and waits at its final step until the output frees.
module eye_blink_counter_core (
  input  logic        clk,
  input  logic        rst_n,
  // Fields, lowest bit up, 13 bits each: outer_corner_x, outer_corner_y,
  // upper_lid_a_x, upper_lid_a_y, upper_lid_b_x, upper_lid_b_y, inner_corner_x,
  // inner_corner_y, lower_lid_b_x, lower_lid_b_y, lower_lid_a_x, lower_lid_a_y;
  // bits 159:156 zero
  input  logic [159:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields, lowest bit up: aspect_ratio[17:0], eye_closed[18], blink_seen[19],
  // blink_total[35:20], closed_run[43:36], zero_width[44]; bits 47:45 zero
  output logic [47:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic                               cfg_we,
  input  logic [ebc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ebc_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import ebc_pkg::*;

  localparam int SUM_W = DIST_W + 1;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  lane_ctl_t         ctl;
  logic              in_fire, fin_fire;

  logic [THR_W-1:0]  thr_r;
  logic [RUN_W-1:0]  min_r;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  blinks_r, blinks_nxt;

  logic [DIST_W-1:0] dist_a, dist_b, dist_c;
  logic [SUM_W-1:0]  vsum, divisor;
  logic              sat, zero;

  logic [SUM_W-1:0]   rem_r;
  logic [RATIO_W-1:0] nq_r;
  logic               sat_r, zero_r;
  logic [SUM_W:0]     trial;
  logic               q_ge;

  logic [RATIO_W-1:0] ratio;
  logic               closed, blink;
  logic               out_valid_r;
  logic [47:0]        out_data_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign fin_fire  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      min_r <= MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATIO_THRESHOLD: thr_r <= cfg_wdata;
        REG_MIN_CLOSED:      min_r <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ctl.load      = in_fire;
    ctl.mul_step  = 1'b0;
    ctl.sqrt_load = 1'b0;
    ctl.sqrt_step = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          step_nxt  = MUL_LAST;
        end
      end
      ST_MUL: begin
        ctl.mul_step = 1'b1;
        step_nxt     = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_SQL;
        end
      end
      ST_SQL: begin
        ctl.sqrt_load = 1'b1;
        state_nxt     = ST_SQRT;
        step_nxt      = SQRT_LAST;
      end
      ST_SQRT: begin
        ctl.sqrt_step = 1'b1;
        step_nxt      = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_DIVL;
        end
      end
      ST_DIVL: begin
        state_nxt = ST_DIV;
        step_nxt  = DIV_LAST;
      end
      ST_DIV: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Distance lanes: A = 1 to 5, B = 2 to 4, C = 0 to 3
  ebc_dist_lane u_lane_a (
    .clk     (clk),
    .ctl     (ctl),
    .p_x     (in_tdata[38:26]),
    .p_y     (in_tdata[51:39]),
    .q_x     (in_tdata[142:130]),
    .q_y     (in_tdata[155:143]),
    .dist_q8 (dist_a)
  );

  ebc_dist_lane u_lane_b (
    .clk     (clk),
    .ctl     (ctl),
    .p_x     (in_tdata[64:52]),
    .p_y     (in_tdata[77:65]),
    .q_x     (in_tdata[116:104]),
    .q_y     (in_tdata[129:117]),
    .dist_q8 (dist_b)
  );

  ebc_dist_lane u_lane_c (
    .clk     (clk),
    .ctl     (ctl),
    .p_x     (in_tdata[12:0]),
    .p_y     (in_tdata[25:13]),
    .q_x     (in_tdata[90:78]),
    .q_y     (in_tdata[103:91]),
    .dist_q8 (dist_c)
  );

  // Divider operands and saturation test: ratio > max exactly when A + B >= 8C
  assign vsum    = {1'b0, dist_a} + {1'b0, dist_b};
  assign divisor = {dist_c, 1'b0};
  assign zero    = (dist_c == '0);
  assign sat     = ({2'b00, vsum} >= {dist_c, 3'b000});

  // Restoring division, one quotient bit per cycle shifted into nq_r
  assign trial = {rem_r, nq_r[RATIO_W-1]};
  assign q_ge  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (state_r == ST_DIVL) begin
      rem_r  <= {2'b00, vsum[SUM_W-1:2]};
      nq_r   <= {vsum[1:0], 16'd0};
      sat_r  <= sat;
      zero_r <= zero;
    end else if (state_r == ST_DIV) begin
      rem_r <= q_ge ? SUM_W'(trial - {1'b0, divisor}) : trial[SUM_W-1:0];
      nq_r  <= {nq_r[RATIO_W-2:0], q_ge};
    end
  end

  // Ratio, closed test and blink state update
  assign ratio  = (zero_r || sat_r) ? RATIO_MAX : nq_r;
  assign closed = !zero_r && (ratio < {2'b00, thr_r});
  assign blink  = !closed && (run_r >= min_r);

  always_comb begin
    if (closed) begin
      run_nxt = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;
    end else begin
      run_nxt = '0;
    end
    blinks_nxt = blink ? blinks_r + 1'b1 : blinks_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= '0;
      blinks_r <= '0;
    end else if (fin_fire) begin
      run_r    <= run_nxt;
      blinks_r <= blinks_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data_r <= {3'b000, zero_r, run_nxt, blinks_nxt, blink, closed, ratio};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/ebc_checker.sv @@
// Port-level checks of eye_blink_counter_core, bound to every instance.
// Depends on assert_macros.svh; no package use.
`include "assert_macros.svh"

module ebc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [47:0]  out_tdata,
  input logic         out_tvalid,
  input logic         out_tready
);

  // Result held until taken
  `EBC_ASSERT(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
    "result dropped or changed while stalled")

  // Reset empties the output
  `EBC_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // An accepted item occupies the block
  `EBC_ASSERT(a_busy, clk, rst_n, in_tvalid && in_tready |=> !in_tready,
    "ready stayed high after a transfer")

  // A blink ends the closed run on an open frame
  `EBC_ASSERT(a_blink_open, clk, rst_n,
    out_tvalid && out_tdata[19] |-> !out_tdata[18] && (out_tdata[43:36] == 8'd0),
    "blink on a closed frame")

  // Zero width saturates and counts as open
  `EBC_ASSERT(a_zero_width, clk, rst_n,
    out_tvalid && out_tdata[44] |-> !out_tdata[18] && (out_tdata[17:0] == 18'h3FFFF),
    "zero width result inconsistent")

endmodule

bind eye_blink_counter_core ebc_checker u_ebc_checker (.*);
